/* sv/ftc_pkg.sv */
// Shared types, constants and a helper function for the FASTA transition counter.
`default_nettype none

package ftc_pkg;

    localparam int COUNT_WIDTH   = 32;
    localparam int CONTEXT_BASES = 3;
    localparam int HIST_W        = 2 * CONTEXT_BASES;
    localparam int IDX_W         = HIST_W + 2;
    localparam int NUM_COUNTERS  = 1 << IDX_W;
    localparam int REGION_W      = 2;
    localparam int VALUE_W       = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    localparam logic [7:0] CHR_GT = 8'h3E;
    localparam logic [7:0] CHR_LF = 8'h0A;
    localparam logic [7:0] CHR_CR = 8'h0D;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_SEQ    = 2'd2
    } parse_mode_t;

    typedef enum logic [1:0] {
        CLS_BASE = 2'd0,
        CLS_DROP = 2'd1,
        CLS_SKIP = 2'd2,
        CLS_BAD  = 2'd3
    } byte_cls_t;

    typedef struct packed {
        byte_cls_t  cls;
        logic [1:0] code;
    } byte_class_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_READ = 2'd1,
        CMD_INC  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [1:0]       status;
    } cmd_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t r;
        r.code = 2'd0;
        case (b)
            "A", "a": r.cls = CLS_BASE;
            "C", "c":
            begin
                r.cls  = CLS_BASE;
                r.code = 2'd1;
            end
            "G", "g":
            begin
                r.cls  = CLS_BASE;
                r.code = 2'd2;
            end
            "T", "t":
            begin
                r.cls  = CLS_BASE;
                r.code = 2'd3;
            end
            "Y", "y", "R", "r", "S", "s", "W", "w", "M", "m", "K", "k",
            "H", "h", "B", "b", "V", "v", "D", "d", "N", "n", "-":
                r.cls = CLS_DROP;
            CHR_CR, CHR_LF: r.cls = CLS_SKIP;
            default: r.cls = CLS_BAD;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/ftc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ftc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ftc_front.sv */
// Front end: FASTA parser that classifies bytes and issues counter commands.
`default_nettype none

module ftc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                operation,
    input  wire logic [7:0]          text_byte,
    input  wire logic [ftc_pkg::IDX_W-1:0] count_index,
    output ftc_pkg::cmd_t            cmd
);

    ftc_pkg::parse_mode_t                mode_reg, mode_next;
    logic [ftc_pkg::HIST_W-1:0]          hist_reg, hist_next;
    logic [ftc_pkg::REGION_W-1:0]        region_reg, region_next;
    logic                                err_reg, err_next;
    ftc_pkg::byte_class_t                bc;

    assign bc = ftc_pkg::classify(text_byte);

    always_comb
    begin
        mode_next = mode_reg;
        if (operation == ftc_pkg::OP_FEED && !err_reg)
        begin
            case (mode_reg)
                ftc_pkg::MODE_WAIT:
                    if (text_byte == ftc_pkg::CHR_GT) mode_next = ftc_pkg::MODE_HEADER;
                ftc_pkg::MODE_HEADER:
                    if (text_byte == ftc_pkg::CHR_LF) mode_next = ftc_pkg::MODE_SEQ;
                default:
                    if (text_byte == ftc_pkg::CHR_GT) mode_next = ftc_pkg::MODE_HEADER;
            endcase
        end
    end

    always_comb
    begin
        cmd.kind    = ftc_pkg::CMD_NONE;
        cmd.idx     = count_index;
        cmd.status  = ftc_pkg::STAT_OK;
        hist_next   = hist_reg;
        region_next = region_reg;
        err_next    = err_reg;
        if (operation == ftc_pkg::OP_READ)
        begin
            cmd.kind = ftc_pkg::CMD_READ;
        end
        else if (err_reg)
        begin
            cmd.status = ftc_pkg::STAT_IGNORED;
        end
        else
        begin
            case (mode_reg)
                ftc_pkg::MODE_WAIT, ftc_pkg::MODE_HEADER: ;
                default:
                begin
                    if (text_byte == ftc_pkg::CHR_GT)
                    begin
                        hist_next   = '0;
                        region_next = '0;
                    end
                    else if (bc.cls == ftc_pkg::CLS_BAD)
                    begin
                        cmd.status = ftc_pkg::STAT_INVALID;
                        err_next   = 1'b1;
                    end
                    else if (bc.cls == ftc_pkg::CLS_BASE)
                    begin
                        if (region_reg == ftc_pkg::REGION_W'(ftc_pkg::CONTEXT_BASES))
                        begin
                            cmd.kind = ftc_pkg::CMD_INC;
                            cmd.idx  = {hist_reg, bc.code};
                        end
                        else
                        begin
                            region_next = region_reg + 1'b1;
                        end
                        hist_next = {hist_reg[ftc_pkg::HIST_W-3:0], bc.code};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ftc_pkg::MODE_WAIT;
            hist_reg   <= '0;
            region_reg <= '0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            hist_reg   <= hist_next;
            region_reg <= region_next;
            err_reg    <= err_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ftc_queue.sv */
// Short command queue between the parser and the counter engine.
`default_nettype none

module ftc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ftc_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output ftc_pkg::cmd_t      head_cmd
);

    ftc_pkg::cmd_t               store [ftc_pkg::QUEUE_DEPTH];
    logic [ftc_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [ftc_pkg::QPTR_W:0]    count_reg, count_next;

    assign full      = (count_reg == (ftc_pkg::QPTR_W+1)'(ftc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

/* sv/ftc_back.sv */
// Back end: counter store read-modify-write with forwarding and output register.
`default_nettype none

module ftc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_not_empty,
    input  wire ftc_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [ftc_pkg::M_DATA_W-1:0] m_tdata
);

    logic                                b_valid_reg;
    ftc_pkg::cmd_t                       b_cmd_reg;
    logic [ftc_pkg::NUM_COUNTERS-1:0]    written_reg;
    logic                                fwd_valid_reg;
    logic [ftc_pkg::IDX_W-1:0]           fwd_addr_reg;
    logic [ftc_pkg::COUNT_WIDTH-1:0]     fwd_data_reg;
    logic                                out_valid_reg;
    logic [ftc_pkg::M_DATA_W-1:0]        out_data_reg, out_data_next;

    logic                            out_ready, b_done, b_take;
    logic [ftc_pkg::COUNT_WIDTH-1:0] rdata, cur, inc_val;
    logic [63:0]                     cur_wide;
    logic [ftc_pkg::VALUE_W-1:0]     value;
    logic                            ram_we, counted;

    assign out_ready = !out_valid_reg || m_tready;
    assign b_done    = b_valid_reg && out_ready;
    assign b_take    = !b_valid_reg || out_ready;
    assign q_pop     = q_not_empty && b_take;

    ftc_ram #(
        .WIDTH (ftc_pkg::COUNT_WIDTH),
        .DEPTH (ftc_pkg::NUM_COUNTERS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_cmd_reg.idx),
        .wdata (inc_val),
        .re    (q_pop),
        .raddr (q_cmd.idx),
        .rdata (rdata)
    );

    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == b_cmd_reg.idx)
            cur = fwd_data_reg;
        else if (written_reg[b_cmd_reg.idx])
            cur = rdata;
        else
            cur = '0;
    end

    assign inc_val  = cur + ftc_pkg::COUNT_WIDTH'(1);
    assign ram_we   = b_done && b_cmd_reg.kind == ftc_pkg::CMD_INC && cur != '1;
    assign counted  = (b_cmd_reg.kind == ftc_pkg::CMD_INC);
    assign cur_wide = 64'(cur);

    always_comb
    begin
        value = '0;
        if (b_cmd_reg.kind == ftc_pkg::CMD_READ)
        begin
            if (cur_wide > 64'h0000_0000_FFFF_FFFF)
                value = '1;
            else
                value = cur_wide[ftc_pkg::VALUE_W-1:0];
        end
    end

    // fields from bit 0: status[1:0], counted[2], count_value[34:3], zero pad
    assign out_data_next = ftc_pkg::M_DATA_W'({value, counted, b_cmd_reg.status});

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_cmd_reg <= q_cmd;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= b_cmd_reg.idx;
            fwd_data_reg <= inc_val;
        end
        if (b_done)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (b_take) b_valid_reg <= q_not_empty;
            if (out_ready) out_valid_reg <= b_valid_reg;
            if (ram_we)
            begin
                fwd_valid_reg              <= 1'b1;
                written_reg[b_cmd_reg.idx] <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_counted_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[2] |-> out_data_reg[1:0] == ftc_pkg::STAT_OK)
        else $error("counted word with nonzero status");
    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> fwd_valid_reg && fwd_addr_reg == $past(b_cmd_reg.idx))
        else $error("forward register missed a write");
`endif

endmodule

`default_nettype wire

/* sv/fasta_trinucleotide_transition_counter.sv */
// Top level of the FASTA order-3 transition counter.
// Usage:
//   The slave stream carries one word per FASTA byte or counter read.
//   s_tuser is the operation: 0 feeds s_tdata[7:0] as a text byte,
//   1 reads the counter addressed by s_tdata[15:8].
//   Every accepted word yields exactly one master word, in order:
//   status, counted flag and, for reads, the 32-bit counter value.
//   Throughput: one word per cycle while m_tready stays high, set by the parser and the
//   one read-modify-write per cycle on the counter RAM with write forwarding.
//   Stalls: a 4-deep command queue, the RAM stage and the output register
//   absorb backpressure; s_tready drops only when the queue is full.
//   Reset: parser returns to waiting for the first '>', error clears, and
//   all 256 counters read zero at once through per-entry written flags;
//   no clearing pass is needed.
`default_nettype none

module fasta_trinucleotide_transition_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // text_byte[7:0], count_index[15:8]
    input  wire logic        s_tuser,  // operation[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // status[1:0], counted[2], count_value[34:3], pad
);

    logic          accept, q_full, q_not_empty, q_pop;
    ftc_pkg::cmd_t front_cmd, head_cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    ftc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (s_tuser),
        .text_byte   (s_tdata[7:0]),
        .count_index (s_tdata[15:8]),
        .cmd         (front_cmd)
    );

    ftc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    ftc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
